[rtl/core/sm4_pkg.sv]
package sm4_pkg;

  // Item opcodes
  localparam logic OP_KEY_WRITE = 1'b0;
  localparam logic OP_ENCRYPT   = 1'b1;

  // Default number of rounds (one round key per round)
  localparam int ROUND_COUNT_DEF = 32;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture a new block into the round state
    logic step;    // run one round on the round state
    logic finish;  // capture the final words into the output register
    logic key_wr;  // store one round key
  } sm4_cmd_t;

  // SM4 S-box
  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // Round transform T: byte substitution, then the linear map L
  function automatic logic [31:0] sm4_t(input logic [31:0] v);
    logic [31:0] b;
    b = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    return b
         ^ {b[29:0], b[31:30]}
         ^ {b[21:0], b[31:22]}
         ^ {b[13:0], b[31:14]}
         ^ {b[7:0],  b[31:8]};
  endfunction

endpackage

[rtl/core/sm4_ctrl.sv]
module sm4_ctrl
  import sm4_pkg::*;
#(
  parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_op,
  output logic                           in_ready,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sm4_cmd_t                       cmd,
  output logic [$clog2(ROUND_COUNT)-1:0] rd_addr
);

  localparam int CNT_W = $clog2(ROUND_COUNT);
  localparam logic [CNT_W-1:0] LAST_RND = CNT_W'(ROUND_COUNT - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept, last, out_free, advance;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign last      = (cnt_r == LAST_RND);
  assign out_free  = !out_valid_r || out_ready;
  // the last round waits until the output register can take the result
  assign advance   = (state_r == ST_RUN) && (!last || out_free);

  // commands and next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    rd_addr       = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_ENCRYPT) begin
            cmd.load  = 1'b1;
            cnt_nxt   = '0;
            rd_addr   = '0;
            state_nxt = ST_RUN;
          end else begin
            cmd.key_wr = 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (advance) begin
          cmd.step = 1'b1;
          if (last) begin
            cmd.finish    = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
            rd_addr = cnt_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/core/sm4_datapath.sv]
module sm4_datapath
  import sm4_pkg::*;
#(
  parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  logic                           clk,
  input  sm4_cmd_t                       cmd,
  input  logic [$clog2(ROUND_COUNT)-1:0] rd_addr,
  input  logic [4:0]                     key_index,
  input  logic [31:0]                    key_word,
  input  logic [63:0]                    block_hi,
  input  logic [63:0]                    block_lo,
  output logic [63:0]                    cipher_hi,
  output logic [63:0]                    cipher_lo
);

  localparam int KEY_AW = $clog2(ROUND_COUNT);

  logic [31:0] key_mem [ROUND_COUNT];
  logic [31:0] key_q_r;
  logic [31:0] x0_r, x1_r, x2_r, x3_r;
  logic [31:0] x_new;
  logic [63:0] cipher_hi_r, cipher_lo_r;

  // round key store, registered read one round ahead
  always_ff @(posedge clk) begin
    if (cmd.key_wr) begin
      key_mem[key_index[KEY_AW-1:0]] <= key_word;
    end
    key_q_r <= key_mem[rd_addr];
  end

  // one round
  assign x_new = x0_r ^ sm4_t(x1_r ^ x2_r ^ x3_r ^ key_q_r);

  // round state shift register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0_r <= block_hi[63:32];
      x1_r <= block_hi[31:0];
      x2_r <= block_lo[63:32];
      x3_r <= block_lo[31:0];
    end else if (cmd.step) begin
      x0_r <= x1_r;
      x1_r <= x2_r;
      x2_r <= x3_r;
      x3_r <= x_new;
    end
  end

  // output register: words in reverse order
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      cipher_hi_r <= {x_new, x3_r};
      cipher_lo_r <= {x2_r, x1_r};
    end
  end

  assign cipher_hi = cipher_hi_r;
  assign cipher_lo = cipher_lo_r;

endmodule

[rtl/core/sm4_block_encrypt.sv]
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_ready   op, key_index, key_word, block_hi, block_lo
// out_     output     out_valid / out_ready cipher_hi, cipher_lo
//
// A key write returns no transaction.
// An encrypt runs ROUND_COUNT rounds, one per cycle through the round state register,
// but the last round waits for the output register, then stores the result and idles.
// rst_n is synchronous; the round key store is not cleared and must be written first.
// A waiting result holds only the last round; new items are accepted while it waits.
module sm4_block_encrypt
  import sm4_pkg::*;
#(
  parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [4:0]  in_key_index,
  input  logic [31:0] in_key_word,
  input  logic [63:0] in_block_hi,
  input  logic [63:0] in_block_lo,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_cipher_hi,
  output logic [63:0] out_cipher_lo
);

  sm4_cmd_t                       cmd;
  logic [$clog2(ROUND_COUNT)-1:0] rd_addr;

  sm4_ctrl #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .rd_addr  (rd_addr)
  );

  sm4_datapath #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .key_index(in_key_index),
    .key_word (in_key_word),
    .block_hi (in_block_hi),
    .block_lo (in_block_lo),
    .cipher_hi(out_cipher_hi),
    .cipher_lo(out_cipher_lo)
  );

endmodule

[rtl/core/sm4_checker.sv]
module sm4_checker
  import sm4_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_op,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_cipher_hi,
  input logic [63:0] out_cipher_lo
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cipher_hi) && $stable(out_cipher_lo))
    else $error("result changed while stalled");

  // an encrypt transaction makes the core busy
  a_enc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_ENCRYPT) |=> !in_ready)
    else $error("input ready right after encrypt");

  // a key write does not stall the input
  a_key_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op == OP_KEY_WRITE) |=> in_ready)
    else $error("key write stalled the input");

  // a new result appears only as the core goes idle
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result raised while busy");

endmodule

bind sm4_block_encrypt sm4_checker u_sm4_checker (.*);

[tb/tb_sm4_block_encrypt.sv]
module tb_sm4_block_encrypt;
  import sm4_pkg::*;

  localparam int NUM_ROUNDS   = 32;
  localparam int ITEM_TARGET  = 1850;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 40;

  // SM4 S-box, entry 0 in the top byte
  localparam logic [0:255][7:0] SBOX_TAB = {
    128'hd690e9fecce13db716b614c228fb2c05, 128'h2b679a762abe04c3aa44132649860699,
    128'h9c4250f491ef987a33540b43edcfac62, 128'he4b31ca9c908e89580df94fa758f3fa6,
    128'h4707a7fcf37317ba83593c19e6854fa8, 128'h686b81b27164da8bf8eb0f4b70569d35,
    128'h1e240e5e6358d1a225227c3b01217887, 128'hd40046579fd327524c3602e7a0c4c89e,
    128'heabf8ad240c738b5a3f7f2cef96115a1, 128'he0ae5da49b341a55ad933230f58cb1e3,
    128'h1df6e22e8266ca60c02923ab0d534e6f, 128'hd5db3745defd8e2f03ff6a726d6c5b51,
    128'h8d1baf92bbddbc7f11d95c411f105ad8, 128'h0ac13188a5cd7bbd2d74d012b8e5b4b0,
    128'h8969974a0c96777e65b9f109c56ec684, 128'h18f07dec3adc4d2079ee5f3ed7cb3948
  };

  typedef logic [NUM_ROUNDS-1:0][31:0] rk_bank_t;

  typedef struct packed {
    logic        op;
    logic [4:0]  idx;
    logic [31:0] word;
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_item_t;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } cipher_blk_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_op = OP_KEY_WRITE;
  logic [4:0]  in_key_index = '0;
  logic [31:0] in_key_word = '0;
  logic [63:0] in_block_hi = '0;
  logic [63:0] in_block_lo = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_cipher_hi;
  logic [63:0] out_cipher_lo;

  sm4_block_encrypt dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_key_index  (in_key_index),
    .in_key_word   (in_key_word),
    .in_block_hi   (in_block_hi),
    .in_block_lo   (in_block_lo),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cipher_hi (out_cipher_hi),
    .out_cipher_lo (out_cipher_lo)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  cipher_item_t pending_q[$];
  cipher_blk_t  cipher_q[$];
  rk_bank_t     rk_store;     // key store as the block should hold it
  rk_bank_t     gen_rk;       // key store as seen while building stimulus
  cipher_item_t drv_item;
  int           err_cnt = 0;
  int           n_key_wr = 0;
  int           n_enc = 0;
  int           n_checked = 0;
  int           n_roundtrip = 0;
  int           burst_left = 1;
  int           gap_left = 0;
  int           idle_cycles = 0;

  // Round transform: byte substitution then linear diffusion
  function automatic logic [31:0] round_t(input logic [31:0] v);
    logic [31:0] b;
    b = {SBOX_TAB[v[31:24]], SBOX_TAB[v[23:16]], SBOX_TAB[v[15:8]], SBOX_TAB[v[7:0]]};
    return b ^ ((b << 2) | (b >> 30)) ^ ((b << 10) | (b >> 22))
             ^ ((b << 18) | (b >> 14)) ^ ((b << 24) | (b >> 8));
  endfunction

  // Full 32-round block transform, output words reversed
  function automatic cipher_blk_t sm4_crypt(input rk_bank_t rk, input logic [63:0] hi,
                                            input logic [63:0] lo);
    logic [31:0] x0, x1, x2, x3, nx;
    cipher_blk_t res;
    x0 = hi[63:32];
    x1 = hi[31:0];
    x2 = lo[63:32];
    x3 = lo[31:0];
    for (int r = 0; r < NUM_ROUNDS; r++) begin
      nx = x0 ^ round_t(x1 ^ x2 ^ x3 ^ rk[r]);
      x0 = x1;
      x1 = x2;
      x2 = x3;
      x3 = nx;
    end
    res.hi = {x3, x2};
    res.lo = {x1, x0};
    return res;
  endfunction

  // Biased 64-bit value: corners, walking ones, walking zeros, random
  function automatic logic [63:0] rand_data64();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      3: return ~(64'd1 << $urandom_range(0, 63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] rand_key32();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Queue a key write; block fields carry junk
  task automatic push_key(input logic [4:0] idx, input logic [31:0] word);
    cipher_item_t it;
    it.op   = OP_KEY_WRITE;
    it.idx  = idx;
    it.word = word;
    it.hi   = {$urandom, $urandom};
    it.lo   = {$urandom, $urandom};
    gen_rk[idx] = word;
    pending_q.push_back(it);
  endtask

  // Queue an encrypt; key fields carry junk
  task automatic push_enc(input logic [63:0] hi, input logic [63:0] lo);
    cipher_item_t it;
    it.op   = OP_ENCRYPT;
    it.idx  = 5'($urandom);
    it.word = $urandom;
    it.hi   = hi;
    it.lo   = lo;
    pending_q.push_back(it);
  endtask

  // Stimulus build, reset and end of run
  initial begin
    int          sel, cnt;
    int          perm[NUM_ROUNDS];
    int          tmp, j;
    rk_bank_t    saved;
    logic [63:0] phi, plo;
    cipher_blk_t ct;

    // Directed: fill the whole key store, corner key values included
    for (int i = 0; i < NUM_ROUNDS; i++) begin
      if (i == 0) push_key(5'(i), '1);
      else if (i == NUM_ROUNDS-1) push_key(5'(i), '0);
      else push_key(5'(i), $urandom);
    end
    push_enc('0, '0);
    push_enc('1, '1);
    push_enc(64'h0123456789abcdef, 64'hfedcba9876543210);
    push_enc(64'ha5a5a5a5a5a5a5a5, 64'h5a5a5a5a5a5a5a5a);
    push_enc(64'h8000000000000000, 64'h0000000000000001);
    push_enc('0, '0);                  // same block, junk key fields differ
    push_key(5'd31, '1);               // rewrite top index
    push_key(5'd0, '0);                // rewrite bottom index
    push_key(5'd0, 32'h0f0f0f0f);      // back-to-back writes to one index
    push_enc('1, '1);

    // Random sequences, mostly well-formed usage
    while (pending_q.size() < ITEM_TARGET) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        cnt = $urandom_range(1, 8);
        repeat (cnt) push_enc(rand_data64(), rand_data64());
      end else if (sel < 65) begin
        cnt = $urandom_range(1, 4);
        repeat (cnt) push_key(5'($urandom), rand_key32());
        cnt = $urandom_range(1, 3);
        repeat (cnt) push_enc(rand_data64(), rand_data64());
      end else if (sel < 75) begin
        // Round trip: encrypt, load reversed keys, decrypt the ciphertext
        phi = rand_data64();
        plo = rand_data64();
        push_enc(phi, plo);
        ct = sm4_crypt(gen_rk, phi, plo);
        saved = gen_rk;
        for (int i = 0; i < NUM_ROUNDS; i++) push_key(5'(i), saved[NUM_ROUNDS-1-i]);
        push_enc(ct.hi, ct.lo);
        n_roundtrip++;
      end else if (sel < 87) begin
        // Fresh key set in shuffled index order
        for (int i = 0; i < NUM_ROUNDS; i++) perm[i] = i;
        for (int i = NUM_ROUNDS-1; i > 0; i--) begin
          j = $urandom_range(0, i);
          tmp = perm[i];
          perm[i] = perm[j];
          perm[j] = tmp;
        end
        for (int i = 0; i < NUM_ROUNDS; i++) push_key(5'(perm[i]), rand_key32());
        cnt = $urandom_range(1, 3);
        repeat (cnt) push_enc(rand_data64(), rand_data64());
      end else begin
        // Noise: repeated writes to one index and mixed corner traffic
        tmp = $urandom_range(0, NUM_ROUNDS-1);
        cnt = $urandom_range(2, 5);
        repeat (cnt) push_key(5'(tmp), rand_key32());
        push_enc($urandom_range(0, 1) ? '0 : '1, rand_data64());
        push_key(5'($urandom), $urandom);
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_q.size() != 0 || in_valid) @(negedge clk);
    while (cipher_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("run covered %0d key writes and %0d block encryptions (%0d round trips)",
             n_key_wr, n_enc, n_roundtrip);
    $display("%0d results checked, %0d mismatches", n_checked, err_cnt);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Driver: bursts of transactions separated by random gaps
  always @(posedge clk) begin : drive_proc
    cipher_item_t nxt;
    logic         nxt_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      nxt_valid = in_valid;
      if (in_valid && in_ready) begin
        // accepted: update predicted key store or queue expected cipher
        if (drv_item.op == OP_KEY_WRITE) begin
          rk_store[drv_item.idx] = drv_item.word;
          n_key_wr++;
        end else begin
          cipher_q.push_back(sm4_crypt(rk_store, drv_item.hi, drv_item.lo));
          n_enc++;
        end
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() > 0) begin
          nxt = pending_q.pop_front();
          drv_item = nxt;
          in_op        <= nxt.op;
          in_key_index <= nxt.idx;
          in_key_word  <= nxt.word;
          in_block_hi  <= nxt.hi;
          in_block_lo  <= nxt.lo;
          nxt_valid = 1'b1;
          if (burst_left <= 1) begin
            if ($urandom_range(0, 5) == 0) begin
              burst_left = $urandom_range(24, 96);   // long run, no gap
              gap_left = 0;
            end else begin
              burst_left = $urandom_range(1, 12);
              gap_left = $urandom_range(0, 40);
            end
          end else begin
            burst_left--;
          end
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // Monitor: receiver backpressure pattern plus result check
  int   rdy_hold = 0;
  int   rdy_mode = 0;
  int   cyc_cnt = 0;
  logic rdy_level = 1'b1;

  always @(posedge clk) begin : mon_proc
    cipher_blk_t exp_blk;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_checked++;
        if (cipher_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("ERROR: unexpected result hi=%h lo=%h", out_cipher_hi, out_cipher_lo);
        end else begin
          exp_blk = cipher_q.pop_front();
          if (out_cipher_hi !== exp_blk.hi) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("ERROR: result %0d cipher_hi expected %h got %h",
                       n_checked, exp_blk.hi, out_cipher_hi);
          end
          if (out_cipher_lo !== exp_blk.lo) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("ERROR: result %0d cipher_lo expected %h got %h",
                       n_checked, exp_blk.lo, out_cipher_lo);
          end
        end
      end
      // pick a new stall style at random, paced by cyc_cnt
      cyc_cnt++;
      if (cyc_cnt % 512 == 0) rdy_mode = $urandom_range(0, 3);
      if (rdy_hold == 0) begin
        case (rdy_mode)
          0: begin
            rdy_level = 1'b1;
            rdy_hold = $urandom_range(1, 50);
          end
          1: begin
            rdy_level = 1'($urandom_range(0, 1));
            rdy_hold = $urandom_range(1, 3);
          end
          2: begin
            rdy_level = ($urandom_range(0, 3) == 0);
            rdy_hold = $urandom_range(1, 8);
          end
          default: begin
            rdy_level = 1'($urandom_range(0, 1));
            rdy_hold = $urandom_range(10, 60);
          end
        endcase
      end
      rdy_hold--;
      out_ready <= rdy_level;
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule

[sim.f]
rtl/core/sm4_pkg.sv
rtl/core/sm4_ctrl.sv
rtl/core/sm4_datapath.sv
rtl/core/sm4_block_encrypt.sv
rtl/core/sm4_checker.sv
tb/tb_sm4_block_encrypt.sv
